// ===== rtl/coil_current_to_weight_defines.svh =====
// Assertion macros for the coil current to weight block.
// Each macro samples on clk and is muted while rst_n is low.
`ifndef COIL_CURRENT_TO_WEIGHT_DEFINES_SVH
`define COIL_CURRENT_TO_WEIGHT_DEFINES_SVH

// Condition holds at every edge
`define CCTW_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define CCTW_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define CCTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cctw_pkg.sv =====
package cctw_pkg;

  // Input op codes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_TARE   = 2'd1;
  localparam logic [1:0] OP_UNIT   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_FULL_SCALE = 2'd0;
  localparam logic [1:0] REG_MAX_TEMP   = 2'd1;
  localparam logic [1:0] REG_G2OZ       = 2'd2;

  // Field widths
  localparam int CUR_W  = 12;
  localparam int TEMP_W = 12;
  localparam int MA_W   = 12;
  localparam int FS_W   = 16;
  localparam int WGT_W  = 16;
  localparam int NET_W  = 17;
  localparam int CFG_W  = 16;

  // Averaging depth and ADC full scale
  localparam int AVG_N          = 3;
  localparam int ADC_FULL_SCALE = 4095;
  localparam int POS_W          = (AVG_N > 1) ? $clog2(AVG_N) : 1;

  // Raw words get their low two bits flipped
  localparam logic [CUR_W-1:0]  CUR_TOGGLE  = CUR_W'(3);
  localparam logic [TEMP_W-1:0] TEMP_TOGGLE = TEMP_W'(3);

  // Shared multiply-add unit operand widths
  localparam int MAC_A_W = 48;
  localparam int MAC_B_W = 18;
  localparam int ACC_W   = 64;

  // Current scaling: p = full_scale * word, mA = p / ADC_FULL_SCALE by reciprocal
  localparam int P_W       = FS_W + CUR_W;
  localparam int ADC_K     = $clog2(ADC_FULL_SCALE) + MA_W;
  localparam int ADC_RECIP = (1 << ADC_K) / ADC_FULL_SCALE;
  localparam logic [P_W-1:0] MA_SAT_P = P_W'(ADC_FULL_SCALE * (1 << MA_W));
  localparam logic [MA_W-1:0] MA_MAX  = {MA_W{1'b1}};

  // Averaging: avg = sum / AVG_N by reciprocal
  localparam int SUM_W     = MA_W + $clog2(AVG_N);
  localparam int AVG_RECIP = (1 << SUM_W) / AVG_N;

  // Q40 calibration coefficients
  localparam int Q_FRAC = 40;
  localparam logic signed [MAC_A_W-1:0] Q40_A3 = -48'sd203619;
  localparam logic signed [ACC_W-1:0]   Q40_A2 = 64'sd1272662719;
  localparam logic signed [ACC_W-1:0]   Q40_A1 = 64'sd360950975701;
  localparam logic signed [MAC_A_W-1:0] Q40_M  = 48'sd1160248650094;
  localparam logic signed [ACC_W-1:0]   Q40_B  = -64'sd23909099448315;
  localparam logic signed [ACC_W-1:0]   Q40_BIAS = 64'sd1099511627775;

  // Integer part of a Q40 value, width left after the fraction is dropped
  localparam int QI_W = ACC_W - Q_FRAC;

  // Request to the shared multiply-add unit: acc <= a * b + c
  typedef struct packed {
    logic                       en;
    logic signed [MAC_A_W-1:0]  a;
    logic signed [MAC_B_W-1:0]  b;
    logic signed [ACC_W-1:0]    c;
  } cctw_mac_req_t;

  // Q40 to integer, truncated toward zero
  function automatic logic signed [QI_W-1:0] q40_trunc(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] biased;
    biased = v + (v[ACC_W-1] ? Q40_BIAS : '0);
    return biased[ACC_W-1:Q_FRAC];
  endfunction

endpackage

// ===== rtl/cctw_mac.sv =====
module cctw_mac (
  input  logic                                     clk,
  input  cctw_pkg::cctw_mac_req_t                  req,
  output logic signed [cctw_pkg::ACC_W-1:0]        acc
);
  import cctw_pkg::*;

  logic signed [MAC_A_W-1:0]         op_a;
  logic signed [MAC_B_W-1:0]         op_b;
  logic signed [MAC_A_W+MAC_B_W-1:0] prod;
  logic signed [ACC_W-1:0]           acc_r;
  logic signed [ACC_W-1:0]           acc_nxt;

  // Multiply, add, register
  assign op_a    = req.a;
  assign op_b    = req.b;
  assign prod    = op_a * op_b;
  assign acc_nxt = prod[ACC_W-1:0] + req.c;

  always_ff @(posedge clk) begin
    if (req.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ===== rtl/coil_current_to_weight.sv =====
// Channel   Direction  Handshake            Payload
// in_       in         in_valid/in_ready    op, current_raw, temperature_raw
// out_      out        out_valid/out_ready  net_grams, display_value, in_ounces, overheat
// cfg_      in         cfg_we               cfg_index, cfg_wdata
//
// A sample request runs the multiply, divide, averaging, calibration and net steps,
// then loads its result and raises in_ready again. Tare and unit requests go straight
// to the net step. One shared 48x18 multiply-add unit is used 10 times per sample.
// Reset is synchronous, active low, and clears the sample ring and all kept state.
// A finished result waits in the output register; the next request runs up to its
// last step and holds there, taking no further request until that result leaves.
module coil_current_to_weight (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_op,
  input  logic [cctw_pkg::CUR_W-1:0]          in_current_raw,
  input  logic [cctw_pkg::TEMP_W-1:0]         in_temperature_raw,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cctw_pkg::NET_W-1:0]   out_net_grams,
  output logic signed [cctw_pkg::NET_W-1:0]   out_display_value,
  output logic                                out_in_ounces,
  output logic                                out_overheat,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [cctw_pkg::CFG_W-1:0]          cfg_wdata
);
  import cctw_pkg::*;

  // Sequencer codes
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MA_MUL  = 4'd1;
  localparam logic [3:0] S_MA_REC  = 4'd2;
  localparam logic [3:0] S_MA_FIX  = 4'd3;
  localparam logic [3:0] S_MA_SAT  = 4'd4;
  localparam logic [3:0] S_AVG_REC = 4'd5;
  localparam logic [3:0] S_AVG_FIX = 4'd6;
  localparam logic [3:0] S_AVG_END = 4'd7;
  localparam logic [3:0] S_P1      = 4'd8;
  localparam logic [3:0] S_P2      = 4'd9;
  localparam logic [3:0] S_P3      = 4'd10;
  localparam logic [3:0] S_CORR    = 4'd11;
  localparam logic [3:0] S_CLAMP   = 4'd12;
  localparam logic [3:0] S_NET     = 4'd13;
  localparam logic [3:0] S_OUT     = 4'd14;

  // Multiplier constants
  localparam logic signed [MAC_B_W-1:0] ADC_RECIP_B = MAC_B_W'(ADC_RECIP);
  localparam logic signed [MAC_B_W-1:0] ADC_NEG_B   = -MAC_B_W'(ADC_FULL_SCALE);
  localparam logic signed [MAC_B_W-1:0] AVG_RECIP_B = MAC_B_W'(AVG_RECIP);
  localparam logic signed [MAC_B_W-1:0] AVG_NEG_B   = -MAC_B_W'(AVG_N);
  localparam logic signed [ACC_W-1:0]   ADC_FS_ACC  = ACC_W'(ADC_FULL_SCALE);
  localparam logic signed [ACC_W-1:0]   AVG_N_ACC   = ACC_W'(AVG_N);
  localparam logic signed [QI_W-1:0]    WGT_MAX_QI  = QI_W'((1 << WGT_W) - 1);
  localparam logic [POS_W-1:0]          POS_LAST    = POS_W'(AVG_N - 1);

  // Control and kept state
  logic [3:0]             state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [MA_W-1:0]        ring_r [AVG_N];
  logic [MA_W-1:0]        ring_nxt [AVG_N];
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [WGT_W-1:0]       cw_r, cw_nxt;
  logic [WGT_W-1:0]       tare_r, tare_nxt;
  logic                   ounce_r, ounce_nxt;
  logic                   overheat_r, overheat_nxt;
  logic [FS_W-1:0]        fs_r, fs_nxt;
  logic [TEMP_W-1:0]      maxt_r, maxt_nxt;
  logic [CFG_W-1:0]       g2o_r, g2o_nxt;

  // Working payload
  logic [CUR_W-1:0]       word_r, word_nxt;
  logic [P_W-1:0]         p_r, p_nxt;
  logic [MA_W-1:0]        q0_r, q0_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [MA_W-1:0]        x_r, x_nxt;
  logic signed [NET_W-1:0] net_r, net_nxt;
  logic signed [NET_W-1:0] onet_r, onet_nxt;
  logic signed [NET_W-1:0] odisp_r, odisp_nxt;
  logic                   oounce_r, oounce_nxt;
  logic                   oheat_r, oheat_nxt;

  // Datapath helpers
  cctw_mac_req_t           mac_req;
  logic signed [ACC_W-1:0] acc;
  logic                    in_acc;
  logic                    out_free;
  logic [SUM_W-1:0]        ring_sum;
  logic [MA_W-1:0]         ma_val;
  logic signed [QI_W-1:0]  qi;
  logic signed [NET_W-1:0] net_val;
  logic [NET_W-1:0]        net_mag;
  logic [NET_W-1:0]        oz;

  cctw_mac u_mac (
    .clk (clk),
    .req (mac_req),
    .acc (acc)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // Ring sum over the kept samples
  always_comb begin
    ring_sum = '0;
    for (int i = 0; i < AVG_N; i++) begin
      ring_sum = ring_sum + SUM_W'(ring_r[i]);
    end
  end

  // Small shared terms
  assign qi      = q40_trunc(acc);
  assign net_val = $signed({1'b0, cw_r}) - $signed({1'b0, tare_r});
  assign net_mag = net_val[NET_W-1] ? NET_W'(-net_val) : NET_W'(net_val);
  assign oz      = acc[16 +: NET_W];
  assign ma_val  = (p_r >= MA_SAT_P) ? MA_MAX :
                   (acc >= ADC_FS_ACC) ? q0_r + MA_W'(1) : q0_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    ring_nxt      = ring_r;
    pos_nxt       = pos_r;
    cw_nxt        = cw_r;
    tare_nxt      = tare_r;
    ounce_nxt     = ounce_r;
    overheat_nxt  = overheat_r;
    fs_nxt        = fs_r;
    maxt_nxt      = maxt_r;
    g2o_nxt       = g2o_r;
    word_nxt      = word_r;
    p_nxt         = p_r;
    q0_nxt        = q0_r;
    sum_nxt       = sum_r;
    x_nxt         = x_r;
    net_nxt       = net_r;
    onet_nxt      = onet_r;
    odisp_nxt     = odisp_r;
    oounce_nxt    = oounce_r;
    oheat_nxt     = oheat_r;
    mac_req       = '0;

    // Result leaves the output register
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FULL_SCALE: fs_nxt   = cfg_wdata[FS_W-1:0];
        REG_MAX_TEMP:   maxt_nxt = cfg_wdata[TEMP_W-1:0];
        REG_G2OZ:       g2o_nxt  = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            OP_SAMPLE: begin
              word_nxt     = in_current_raw ^ CUR_TOGGLE;
              overheat_nxt = (in_temperature_raw ^ TEMP_TOGGLE) > maxt_r;
              state_nxt    = S_MA_MUL;
            end
            OP_TARE: begin
              tare_nxt  = cw_r;
              state_nxt = S_NET;
            end
            OP_UNIT: begin
              ounce_nxt = !ounce_r;
              state_nxt = S_NET;
            end
            default: state_nxt = S_NET;
          endcase
        end
      end
      // p = full_scale * word
      S_MA_MUL: begin
        mac_req.en = 1'b1;
        mac_req.a  = {{(MAC_A_W-FS_W){1'b0}}, fs_r};
        mac_req.b  = {{(MAC_B_W-CUR_W){1'b0}}, word_r};
        state_nxt  = S_MA_REC;
      end
      // quotient estimate by reciprocal
      S_MA_REC: begin
        p_nxt      = acc[P_W-1:0];
        mac_req.en = 1'b1;
        mac_req.a  = {{(MAC_A_W-P_W){1'b0}}, acc[P_W-1:0]};
        mac_req.b  = ADC_RECIP_B;
        state_nxt  = S_MA_FIX;
      end
      // remainder of the estimate
      S_MA_FIX: begin
        q0_nxt     = acc[ADC_K +: MA_W];
        mac_req.en = 1'b1;
        mac_req.a  = {{(MAC_A_W-MA_W){1'b0}}, acc[ADC_K +: MA_W]};
        mac_req.b  = ADC_NEG_B;
        mac_req.c  = {{(ACC_W-P_W){1'b0}}, p_r};
        state_nxt  = S_MA_SAT;
      end
      // correct, saturate, push into the ring
      S_MA_SAT: begin
        ring_nxt[pos_r] = ma_val;
        pos_nxt         = (pos_r == POS_LAST) ? '0 : pos_r + POS_W'(1);
        state_nxt       = S_AVG_REC;
      end
      S_AVG_REC: begin
        sum_nxt    = ring_sum;
        mac_req.en = 1'b1;
        mac_req.a  = {{(MAC_A_W-SUM_W){1'b0}}, ring_sum};
        mac_req.b  = AVG_RECIP_B;
        state_nxt  = S_AVG_FIX;
      end
      S_AVG_FIX: begin
        q0_nxt     = acc[SUM_W +: MA_W];
        mac_req.en = 1'b1;
        mac_req.a  = {{(MAC_A_W-MA_W){1'b0}}, acc[SUM_W +: MA_W]};
        mac_req.b  = AVG_NEG_B;
        mac_req.c  = {{(ACC_W-SUM_W){1'b0}}, sum_r};
        state_nxt  = S_AVG_END;
      end
      S_AVG_END: begin
        x_nxt     = (acc >= AVG_N_ACC) ? q0_r + MA_W'(1) : q0_r;
        state_nxt = S_P1;
      end
      // Horner: ((A3*x + A2)*x + A1)*x
      S_P1: begin
        mac_req.en = 1'b1;
        mac_req.a  = Q40_A3;
        mac_req.b  = {{(MAC_B_W-MA_W){1'b0}}, x_r};
        mac_req.c  = Q40_A2;
        state_nxt  = S_P2;
      end
      S_P2: begin
        mac_req.en = 1'b1;
        mac_req.a  = acc[MAC_A_W-1:0];
        mac_req.b  = {{(MAC_B_W-MA_W){1'b0}}, x_r};
        mac_req.c  = Q40_A1;
        state_nxt  = S_P3;
      end
      S_P3: begin
        mac_req.en = 1'b1;
        mac_req.a  = acc[MAC_A_W-1:0];
        mac_req.b  = {{(MAC_B_W-MA_W){1'b0}}, x_r};
        state_nxt  = S_CORR;
      end
      // linear correction on the truncated cubic
      S_CORR: begin
        mac_req.en = 1'b1;
        mac_req.a  = Q40_M;
        mac_req.b  = qi[MAC_B_W-1:0];
        mac_req.c  = Q40_B;
        state_nxt  = S_CLAMP;
      end
      S_CLAMP: begin
        if (qi[QI_W-1]) begin
          cw_nxt = '0;
        end else if (qi > WGT_MAX_QI) begin
          cw_nxt = {WGT_W{1'b1}};
        end else begin
          cw_nxt = qi[WGT_W-1:0];
        end
        state_nxt = S_NET;
      end
      // net weight and ounce product
      S_NET: begin
        net_nxt    = net_val;
        mac_req.en = 1'b1;
        mac_req.a  = {{(MAC_A_W-NET_W){1'b0}}, net_mag};
        mac_req.b  = {{(MAC_B_W-CFG_W){1'b0}}, g2o_r};
        state_nxt  = S_OUT;
      end
      // load the result once the output register is free
      S_OUT: begin
        if (out_free) begin
          onet_nxt      = net_r;
          odisp_nxt     = !ounce_r ? net_r :
                          net_r[NET_W-1] ? $signed(-oz) : $signed(oz);
          oounce_nxt    = ounce_r;
          oheat_nxt     = overheat_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and kept state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < AVG_N; i++) begin
        ring_r[i] <= '0;
      end
      pos_r       <= '0;
      cw_r        <= '0;
      tare_r      <= '0;
      ounce_r     <= 1'b0;
      overheat_r  <= 1'b0;
      fs_r        <= FS_W'(1000);
      maxt_r      <= TEMP_W'(4095);
      g2o_r       <= CFG_W'(2312);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ring_r      <= ring_nxt;
      pos_r       <= pos_nxt;
      cw_r        <= cw_nxt;
      tare_r      <= tare_nxt;
      ounce_r     <= ounce_nxt;
      overheat_r  <= overheat_nxt;
      fs_r        <= fs_nxt;
      maxt_r      <= maxt_nxt;
      g2o_r       <= g2o_nxt;
    end
  end

  // Working payload
  always_ff @(posedge clk) begin
    word_r   <= word_nxt;
    p_r      <= p_nxt;
    q0_r     <= q0_nxt;
    sum_r    <= sum_nxt;
    x_r      <= x_nxt;
    net_r    <= net_nxt;
    onet_r   <= onet_nxt;
    odisp_r  <= odisp_nxt;
    oounce_r <= oounce_nxt;
    oheat_r  <= oheat_nxt;
  end

  assign out_net_grams     = onet_r;
  assign out_display_value = odisp_r;
  assign out_in_ounces     = oounce_r;
  assign out_overheat      = oheat_r;

`include "coil_current_to_weight_defines.svh"

  `CCTW_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
                    "ready right after accept")
  `CCTW_ASSERT_IMPLIES(a_grams_passthru, out_valid && !out_in_ounces,
                       out_display_value == out_net_grams, "gram display differs from net")
  `CCTW_ASSERT_ALWAYS(a_ring_pos, pos_r <= POS_LAST, "ring position out of range")
  `CCTW_ASSERT_NEXT(a_out_load, state_r == S_OUT && out_free, out_valid && in_ready,
                    "result not loaded")

endmodule

// ===== tb/weight_reading_checker.sv =====
// Watches the request, result and register ports of coil_current_to_weight,
// predicts each result and compares it with what the block returns.
module weight_reading_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [1:0]                        in_op,
  input  logic [cctw_pkg::CUR_W-1:0]        in_current_raw,
  input  logic [cctw_pkg::TEMP_W-1:0]       in_temperature_raw,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [cctw_pkg::NET_W-1:0] out_net_grams,
  input  logic signed [cctw_pkg::NET_W-1:0] out_display_value,
  input  logic                              out_in_ounces,
  input  logic                              out_overheat,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [cctw_pkg::CFG_W-1:0]        cfg_wdata,
  output int                                mismatches,
  output int                                readings_due
);
  import cctw_pkg::*;

  // Calibration coefficients, signed Q40
  localparam longint COEF_A1 = 64'sd360950975701;
  localparam longint COEF_A2 = 64'sd1272662719;
  localparam longint COEF_A3 = -64'sd203619;
  localparam longint COEF_M  = 64'sd1160248650094;
  localparam longint COEF_B  = -64'sd23909099448315;
  localparam longint MA_CEIL     = 4095;
  localparam longint WEIGHT_CEIL = 65535;

  typedef struct packed {
    logic signed [NET_W-1:0] net_grams;
    logic signed [NET_W-1:0] display_value;
    logic                    in_ounces;
    logic                    overheat;
  } weight_reading_t;

  // Shadow of the block's kept state and registers
  logic [MA_W-1:0]  ring [AVG_N];
  int               ring_pos;
  logic [WGT_W-1:0] weight_now;
  logic [WGT_W-1:0] tare;
  logic             ounce_mode;
  logic             hot;
  logic [15:0]      full_scale_ma;
  logic [11:0]      temp_limit;
  logic [15:0]      oz_factor_q16;

  weight_reading_t expected_readings [$];
  weight_reading_t want;

  // Q40 to integer, truncated toward zero
  function automatic longint q40_to_int(input longint v);
    return (v < 0) ? -((-v) >>> Q_FRAC) : (v >>> Q_FRAC);
  endfunction

  // Apply one request to the shadow state and return the reading it produces
  function automatic weight_reading_t predict_reading(input logic [1:0] op,
                                                      input logic [CUR_W-1:0] cur,
                                                      input logic [TEMP_W-1:0] temp);
    longint ma, sum, avg, poly, grams, corr, net, oz;
    weight_reading_t r;
    case (op)
      OP_SAMPLE: begin
        ma = (longint'(full_scale_ma) * longint'(cur ^ CUR_TOGGLE)) / ADC_FULL_SCALE;
        if (ma > MA_CEIL) ma = MA_CEIL;
        ring[ring_pos] = ma[MA_W-1:0];
        ring_pos = (ring_pos + 1) % AVG_N;
        sum = 0;
        for (int i = 0; i < AVG_N; i++) sum += longint'(ring[i]);
        avg = sum / AVG_N;
        // cubic calibration, then linear correction, both exact in Q40
        poly = COEF_A1 * avg + COEF_A2 * avg * avg + COEF_A3 * avg * avg * avg;
        grams = q40_to_int(poly);
        corr = q40_to_int(COEF_M * grams + COEF_B);
        if (corr < 0) corr = 0;
        else if (corr > WEIGHT_CEIL) corr = WEIGHT_CEIL;
        weight_now = corr[WGT_W-1:0];
        hot = (temp ^ TEMP_TOGGLE) > temp_limit;
      end
      OP_TARE: tare = weight_now;
      OP_UNIT: ounce_mode = !ounce_mode;
      default: ;
    endcase
    net = longint'(weight_now) - longint'(tare);
    oz = ((net < 0 ? -net : net) * longint'(oz_factor_q16)) >>> 16;
    if (net < 0) oz = -oz;
    r.net_grams     = net[NET_W-1:0];
    r.display_value = ounce_mode ? oz[NET_W-1:0] : net[NET_W-1:0];
    r.in_ounces     = ounce_mode;
    r.overheat      = hot;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AVG_N; i++) ring[i] = '0;
      ring_pos      = 0;
      weight_now    = '0;
      tare          = '0;
      ounce_mode    = 1'b0;
      hot           = 1'b0;
      full_scale_ma = 16'd1000;
      temp_limit    = 12'd4095;
      oz_factor_q16 = 16'd2312;
      mismatches    = 0;
      expected_readings.delete();
    end else begin
      // register writes land before any request of the same edge
      if (cfg_we) begin
        case (cfg_index)
          REG_FULL_SCALE: full_scale_ma = cfg_wdata;
          REG_MAX_TEMP:   temp_limit = cfg_wdata[11:0];
          REG_G2OZ:       oz_factor_q16 = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_readings.push_back(predict_reading(in_op, in_current_raw, in_temperature_raw));
      // compare each returned result with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          $error("result with no request pending: net_grams %0d", out_net_grams);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          if (out_net_grams !== want.net_grams) begin
            $error("net_grams: expected %0d, actual %0d", want.net_grams, out_net_grams);
            mismatches++;
          end
          if (out_display_value !== want.display_value) begin
            $error("display_value: expected %0d, actual %0d",
                   want.display_value, out_display_value);
            mismatches++;
          end
          if (out_in_ounces !== want.in_ounces) begin
            $error("in_ounces: expected %0b, actual %0b", want.in_ounces, out_in_ounces);
            mismatches++;
          end
          if (out_overheat !== want.overheat) begin
            $error("overheat: expected %0b, actual %0b", want.overheat, out_overheat);
            mismatches++;
          end
        end
      end
    end
    readings_due = expected_readings.size();
  end

endmodule

// ===== tb/tb.sv =====
// Stimulus and verdict for coil_current_to_weight; checking lives in
// weight_reading_checker.
module tb;
  import cctw_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 24;
  localparam int PHASE_REQUESTS  = 370;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_op = OP_SAMPLE;
  logic [CUR_W-1:0]        in_current_raw = '0;
  logic [TEMP_W-1:0]       in_temperature_raw = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [NET_W-1:0] out_net_grams;
  logic signed [NET_W-1:0] out_display_value;
  logic                    out_in_ounces;
  logic                    out_overheat;
  logic                    cfg_we = 1'b0;
  logic [1:0]              cfg_index = REG_FULL_SCALE;
  logic [CFG_W-1:0]        cfg_wdata = '0;

  int          mismatches;
  int          readings_due;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;
  logic        hold_req = 1'b0;
  logic [11:0] temp_limit_now = 12'd4095;

  coil_current_to_weight dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_current_raw(in_current_raw), .in_temperature_raw(in_temperature_raw),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_net_grams(out_net_grams), .out_display_value(out_display_value),
    .out_in_ounces(out_in_ounces), .out_overheat(out_overheat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  weight_reading_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_current_raw(in_current_raw), .in_temperature_raw(in_temperature_raw),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_net_grams(out_net_grams), .out_display_value(out_display_value),
    .out_in_ounces(out_in_ounces), .out_overheat(out_overheat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .readings_due(readings_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog on handshake progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one request, after a random idle gap, and wait for acceptance
  task automatic offer(input logic [1:0] op, input logic [11:0] cur, input logic [11:0] temp);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid           <= 1'b1;
    in_op              <= op;
    in_current_raw     <= cur;
    in_temperature_raw <= temp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending until every result is back, then let the block settle;
  // one edge first so the count includes the request just accepted
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (readings_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] fs, input logic [11:0] mt, input logic [15:0] oz);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FULL_SCALE;
    cfg_wdata <= fs;
    @(posedge clk);
    cfg_index <= REG_MAX_TEMP;
    cfg_wdata <= CFG_W'(mt);
    @(posedge clk);
    cfg_index <= REG_G2OZ;
    cfg_wdata <= oz;
    @(posedge clk);
    cfg_we <= 1'b0;
    temp_limit_now = mt;
  endtask

  // Mostly samples; currents hit the extremes now and then, temperatures
  // often sit right at the overheat threshold
  task automatic offer_random();
    int pick;
    logic [1:0] op;
    logic [11:0] cur;
    logic [11:0] temp;
    pick = $urandom_range(99);
    op = (pick < 70) ? OP_SAMPLE : (pick < 82) ? OP_TARE : (pick < 94) ? OP_UNIT : OP_UNUSED;
    cur = 12'($urandom_range(4095));
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: cur = 12'd0;
        1: cur = 12'hFFF;
        2: cur = 12'd3;
        default: cur = 12'hFFC;
      endcase
    end
    if ($urandom_range(1) == 0)
      temp = 12'($urandom_range(4095));
    else
      temp = (temp_limit_now ^ 12'd3) + 12'($urandom_range(4)) - 12'd2;
    offer(op, cur, temp);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every op, tare below zero, ounces, unused op
    configure(16'd1000, 12'd2000, 16'd2312);
    offer(OP_SAMPLE, 12'd0, 12'd0);
    offer(OP_SAMPLE, 12'hFFF, 12'hFFF);
    offer(OP_SAMPLE, 12'd3, 12'd3);
    offer(OP_SAMPLE, 12'hFFC, 12'd2003);
    offer(OP_SAMPLE, 12'd2000, 12'd2000);
    offer(OP_TARE, 12'hFFF, 12'hFFF);
    offer(OP_SAMPLE, 12'd100, 12'd0);
    offer(OP_UNIT, 12'd0, 12'd0);
    offer(OP_SAMPLE, 12'hFFF, 12'd0);
    offer(OP_UNUSED, 12'hFFF, 12'hFFF);
    offer(OP_TARE, 12'd0, 12'd0);
    offer(OP_SAMPLE, 12'd0, 12'd0);
    offer(OP_UNIT, 12'hAAA, 12'h555);
    offer(OP_UNUSED, 12'd0, 12'd0);
    drain();
    configure(16'hFFFF, 12'd0, 16'hFFFF);
    offer(OP_SAMPLE, 12'hFFF, 12'd3);
    offer(OP_SAMPLE, 12'd1, 12'd2);
    offer(OP_SAMPLE, 12'd2048, 12'd0);
    offer(OP_UNIT, 12'd0, 12'd0);
    offer(OP_TARE, 12'd0, 12'd0);
    offer(OP_SAMPLE, 12'd3, 12'hFFF);
    drain();
    configure(16'd0, 12'hFFF, 16'd0);
    offer(OP_SAMPLE, 12'hFFF, 12'hFFC);
    offer(OP_SAMPLE, 12'd0, 12'hFFF);
    offer(OP_UNIT, 12'd0, 12'd0);

    // Random phases, each with its own idling and register setting
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          configure(16'd4095, 12'($urandom_range(4095)), 16'd2312);
        end
        1: begin
          idle_pct = 75;
          stall_pct = 0;
          configure(16'hFFFF, 12'hFFF, 16'hFFFF);
        end
        2: begin
          idle_pct = 0;
          stall_pct = 75;
          configure(16'($urandom_range(65535)), 12'd0, 16'($urandom_range(65535)));
        end
        default: begin
          idle_pct = 29;
          stall_pct = 29;
          configure(16'd1000, 12'($urandom_range(4095)), 16'd0);
        end
      endcase
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        // long result hold-off while requests keep coming
        if (ph == 2 && n == 100) hold_req = 1'b1;
        if (n == 200) drain();
        offer_random();
      end
    end

    drain();
    if (mismatches == 0 && readings_due == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cctw_pkg.sv
rtl/cctw_mac.sv
rtl/coil_current_to_weight.sv
tb/weight_reading_checker.sv
tb/tb.sv
